### sv/tbs_pkg.sv
// Package for the timer bank scheduler: transfer structs, operation codes,
// the per-timer entry layout and the controller state type.
// No dependencies; the top level imports it, tbs_ram does not.
`timescale 1ns / 1ps
`default_nettype none

package tbs_pkg;

    // Default number of timers in the bank.
    localparam int NUM_TIMERS_DEF = 64;

    // Width of a timer id in the transfer fields.
    localparam int ID_W = 6;

    // Largest positive 32-bit signed distance.
    localparam logic [31:0] MAX_DISTANCE = 32'h7FFF_FFFF;

    // Operation codes carried in the func field.
    localparam logic [2:0] FUNC_TICK  = 3'd0;
    localparam logic [2:0] FUNC_SET   = 3'd1;
    localparam logic [2:0] FUNC_START = 3'd2;
    localparam logic [2:0] FUNC_STOP  = 3'd3;
    localparam logic [2:0] FUNC_CLEAR = 3'd4;

    // One command transfer.
    typedef struct packed {
        logic [2:0]      func;
        logic [ID_W-1:0] timer_id;
        logic [31:0]     timeout;
        logic [31:0]     period;
    } cmd_t;

    // One result transfer.
    typedef struct packed {
        logic [ID_W-1:0] expired_id;
        logic            last;
    } result_t;

    // One entry of the timer memory.
    typedef struct packed {
        logic        armed;
        logic [31:0] reload;
        logic [31:0] deadline;
    } entry_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW,
        ST_SCAN,
        ST_FLUSH
    } state_t;

endpackage

`default_nettype wire

### sv/tbs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No package dependencies; used for the timer entry memory.
`timescale 1ns / 1ps
`default_nettype none

module tbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### sv/timer_bank_scheduler.sv
// Top level of the timer bank scheduler: command decode, tick scan engine
// and the timer entry memory. Depends on tbs_pkg and tbs_ram.
//
//   Channel   Direction  Handshake                    Payload
//   command   in         start high while busy low    cmd    (cmd_t)
//   result    out        result_valid, one cycle      result (result_t)
//
// Set and clear write their entry from idle; start and stop read the entry,
// then write it back in ST_RMW. A tick without a scan stays idle; a tick
// that scans reads one timer entry per cycle from the single-read-port
// entry memory: first read from idle, each entry evaluated in ST_SCAN, and
// the finish in ST_FLUSH. After reset the block clears the entry memory,
// one entry per cycle, with busy high. The receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none

module timer_bank_scheduler
    import tbs_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    result_valid,
    output result_t result
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int ENT_W = $bits(entry_t);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    // Control registers.
    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [31:0]       now_reg, now_next;
    logic [31:0]       next_due_reg, next_due_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              result_valid_reg, result_valid_next;

    // Payload registers.
    logic [31:0]       base_reg, base_next;
    logic [31:0]       nearest_reg, nearest_next;
    logic [ID_W-1:0]   pend_id_reg, pend_id_next;
    logic [2:0]        op_reg, op_next;
    logic [IDX_W-1:0]  op_addr_reg, op_addr_next;
    result_t           result_reg, result_next;

    // Memory ports.
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    entry_t            mem_wdata;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    logic [ENT_W-1:0]  mem_rdata;
    entry_t            rd_entry;

    // Datapath terms.
    logic              accept;
    logic [31:0]       id_ext;
    logic              id_ok;
    logic [IDX_W-1:0]  id_addr;
    logic [31:0]       idx_ext;
    logic [31:0]       set_dl;
    logic [31:0]       set_diff;
    logic [31:0]       now_inc;
    logic [31:0]       tick_diff;
    logic [31:0]       scan_d;
    logic              d_pos;
    logic              expire;
    logic              reload_pos;
    logic              cand_valid;
    logic [31:0]       cand;
    logic [31:0]       reload_dl;

    tbs_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_TIMERS),
        .AW    (IDX_W)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // Handshake and command address decode.
    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign id_ext   = 32'(cmd.timer_id);
    assign id_ok    = (id_ext < 32'(NUM_TIMERS));
    assign id_addr  = id_ext[IDX_W-1:0];
    assign idx_ext  = 32'(idx_reg);

    // Command arithmetic on the time count.
    assign set_dl    = now_reg + cmd.timeout;
    assign set_diff  = set_dl - next_due_reg;
    assign now_inc   = now_reg + 32'd1;
    assign tick_diff = next_due_reg - now_inc;

    // Evaluation of the entry read during a scan.
    assign rd_entry   = entry_t'(mem_rdata);
    assign scan_d     = rd_entry.deadline - base_reg;
    assign d_pos      = (scan_d != 32'd0) && !scan_d[31];
    assign expire     = rd_entry.armed && !d_pos;
    assign reload_pos = (rd_entry.reload != 32'd0) && !rd_entry.reload[31];
    assign cand_valid = expire ? reload_pos : (rd_entry.armed && d_pos);
    assign cand       = expire ? rd_entry.reload : scan_d;
    assign reload_dl  = base_reg + rd_entry.reload;

    // Next state, memory control and result generation.
    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        now_next          = now_reg;
        next_due_next     = next_due_reg;
        pend_valid_next   = pend_valid_reg;
        result_valid_next = 1'b0;
        base_next         = base_reg;
        nearest_next      = nearest_reg;
        pend_id_next      = pend_id_reg;
        op_next           = op_reg;
        op_addr_next      = op_addr_reg;
        result_next       = result_reg;
        mem_we            = 1'b0;
        mem_waddr         = idx_reg;
        mem_wdata         = '0;
        mem_re            = 1'b0;
        mem_raddr         = idx_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Sweep zeros through the entry memory after reset.
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = '0;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.func)
                        FUNC_TICK:
                        begin
                            now_next = now_inc;
                            if (tick_diff[31])
                            begin
                                base_next       = next_due_reg;
                                nearest_next    = MAX_DISTANCE;
                                pend_valid_next = 1'b0;
                                idx_next        = '0;
                                mem_re          = 1'b1;
                                mem_raddr       = '0;
                                state_next      = ST_SCAN;
                            end
                        end
                        FUNC_SET:
                        begin
                            if (id_ok)
                            begin
                                mem_we             = 1'b1;
                                mem_waddr          = id_addr;
                                mem_wdata.armed    = 1'b1;
                                mem_wdata.reload   = cmd.period;
                                mem_wdata.deadline = set_dl;
                                if (set_diff[31])
                                begin
                                    next_due_next = set_dl;
                                end
                            end
                        end
                        FUNC_START, FUNC_STOP:
                        begin
                            if (id_ok)
                            begin
                                mem_re       = 1'b1;
                                mem_raddr    = id_addr;
                                op_next      = cmd.func;
                                op_addr_next = id_addr;
                                state_next   = ST_RMW;
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            if (id_ok)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = id_addr;
                                mem_wdata = '0;
                            end
                        end
                        default:
                        begin
                            // Unknown operations are ignored.
                        end
                    endcase
                end
            end

            ST_RMW:
            begin
                // Write back the entry with only the armed mark changed.
                mem_we             = 1'b1;
                mem_waddr          = op_addr_reg;
                mem_wdata.armed    = (op_reg == FUNC_START);
                mem_wdata.reload   = rd_entry.reload;
                mem_wdata.deadline = rd_entry.deadline;
                state_next         = ST_IDLE;
            end

            ST_SCAN:
            begin
                // Expiry: reload or disarm, and hold the id back by one so
                // that the final expiry of the scan can carry the last mark.
                if (expire)
                begin
                    mem_we           = 1'b1;
                    mem_waddr        = idx_reg;
                    mem_wdata.reload = rd_entry.reload;
                    if (rd_entry.reload != 32'd0)
                    begin
                        mem_wdata.armed    = 1'b1;
                        mem_wdata.deadline = reload_dl;
                    end
                    else
                    begin
                        mem_wdata.armed    = 1'b0;
                        mem_wdata.deadline = rd_entry.deadline;
                    end
                    if (pend_valid_reg)
                    begin
                        result_valid_next      = 1'b1;
                        result_next.expired_id = pend_id_reg;
                        result_next.last       = 1'b0;
                    end
                    pend_id_next    = idx_ext[ID_W-1:0];
                    pend_valid_next = 1'b1;
                end

                // Track the nearest pending distance.
                if (cand_valid && (cand < nearest_reg))
                begin
                    nearest_next = cand;
                end

                // Advance to the next entry or finish the scan.
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    idx_next  = idx_reg + 1'b1;
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg + 1'b1;
                end
            end

            ST_FLUSH:
            begin
                if (pend_valid_reg)
                begin
                    result_valid_next      = 1'b1;
                    result_next.expired_id = pend_id_reg;
                    result_next.last       = 1'b1;
                end
                pend_valid_next = 1'b0;
                next_due_next   = base_reg + nearest_reg;
                idx_next        = '0;
                state_next      = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state with asynchronous reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            idx_reg          <= '0;
            now_reg          <= '0;
            next_due_reg     <= '0;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            now_reg          <= now_next;
            next_due_reg     <= next_due_next;
            pend_valid_reg   <= pend_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        base_reg    <= base_next;
        nearest_reg <= nearest_next;
        pend_id_reg <= pend_id_next;
        op_reg      <= op_next;
        op_addr_reg <= op_addr_next;
        result_reg  <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire
